// ===== rtl/cho_pkg.sv =====
// Shared constants, register indexes and control types of the stereo chorus.
package cho_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 22;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LFO_STEP   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_DELAY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_DEPTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH      = 3'd5;

   // Field widths
   localparam int LFO_W   = 32;
   localparam int STEP_W  = 22;
   localparam int DELAY_W = 20;
   localparam int MIX_W   = 16;
   localparam int WIDTH_W = 17;

   // Register reset values
   localparam logic [STEP_W-1:0]  RST_LFO_STEP   = 22'd44739;
   localparam logic [DELAY_W-1:0] RST_BASE_DELAY = 20'd61440;
   localparam logic [MIX_W-1:0]   RST_MIX        = 16'd16384;

   // Unity in Q1.15
   localparam logic [16:0] Q15_ONE = 17'd32768;

   // Sine shaping correction factor
   localparam logic [12:0] SINE_CORR = 13'd7373;

   typedef struct packed {
      logic [LFO_W-1:0]   phase;
      logic [DELAY_W-1:0] base_delay;
      logic [DELAY_W-1:0] mod_depth;
   } lane_cfg_type;

   typedef struct packed {
      logic [MIX_W-1:0]   mix;
      logic [WIDTH_W-1:0] width;
   } mix_cfg_type;

endpackage

// ===== rtl/cho_if.sv =====
// Request and response channel interfaces of the stereo chorus.
interface cho_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface cho_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/multi_voice_stereo_chorus_top.sv =====
// Top level of the multi-voice stereo chorus: registers, frame control and lanes.
// Takes one stereo frame per item and returns one mixed frame. With the chorus
// enabled an item passes through the 16-step voice sequencer, which all lanes
// run side by side, then the merge (load, reciprocal average, scale, mix), and
// is then loaded into the output register. With the chorus disabled an item goes
// straight to the output register. A new item is accepted once the previous
// result is in the output register.
// The delay lines read as zero until written; a fill count tracks this, so no
// clearing pass runs after reset.
module multi_voice_stereo_chorus_top #(
   parameter int VOICES       = 4,
   parameter int DELAY_DEPTH  = 4096,
   parameter int SAMPLE_BITS  = 24,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   cho_req_if.sink                             req_if,
   cho_rsp_if.source                           rsp_if,
   input  logic                                csr_wr_en,
   input  logic [cho_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cho_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import cho_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int FW = $clog2(DELAY_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);
   localparam logic [FW-1:0] FULL = FW'(DELAY_DEPTH);

   // Frame states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LANE  = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic               enable_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [DELAY_W-1:0] base_ff;
   logic [DELAY_W-1:0] depth_ff;
   logic [MIX_W-1:0]   mix_ff;
   logic [WIDTH_W-1:0] width_ff;

   logic [1:0]        state_ff, state_in;
   logic              proc_ff;
   logic [AW-1:0]     wr_index_ff;
   logic [LFO_W-1:0]  phase_ff;
   logic [FW-1:0]     fill_ff;
   logic signed [SB-1:0] dry_l_ff, dry_r_ff;
   logic signed [SB-1:0] res_l_ff, res_r_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   logic signed [SB-1:0] out_l_ff, out_r_ff;

   logic              accept;
   logic              load_out;
   logic              lane_start;
   logic              merge_start;
   logic [VOICES-1:0] lane_done;
   logic              merge_done;
   logic signed [SB-1:0] lane_l [VOICES];
   logic signed [SB-1:0] lane_r [VOICES];
   logic signed [SB-1:0] mg_l, mg_r;
   lane_cfg_type      lane_cfg;
   mix_cfg_type       mix_cfg;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         step_ff   <= RST_LFO_STEP;
         base_ff   <= RST_BASE_DELAY;
         depth_ff  <= '0;
         mix_ff    <= RST_MIX;
         width_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE:     enable_ff <= csr_wr_data[0];
            CSR_LFO_STEP:   step_ff   <= csr_wr_data[STEP_W-1:0];
            CSR_BASE_DELAY: base_ff   <= csr_wr_data[DELAY_W-1:0];
            CSR_MOD_DEPTH:  depth_ff  <= csr_wr_data[DELAY_W-1:0];
            CSR_MIX:        mix_ff    <= csr_wr_data[MIX_W-1:0];
            CSR_WIDTH:      width_ff  <= csr_wr_data[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake
   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign load_out     = (state_ff == ST_OUT) && (!rsp_vld_ff || rsp_if.ready);
   assign lane_start   = accept && enable_ff;
   assign merge_start  = (state_ff == ST_LANE) && (&lane_done);

   // Frame control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = enable_ff ? ST_LANE : ST_OUT;
            end
         end
         ST_LANE: begin
            if (&lane_done) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (merge_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result until it is taken
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (load_out) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rsp_vld_ff  <= 1'b0;
         proc_ff     <= 1'b0;
         wr_index_ff <= '0;
         phase_ff    <= '0;
         fill_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         if (accept) begin
            proc_ff <= enable_ff;
         end
         // Advance the write slot, fill count and LFO after a processed frame
         if (load_out && proc_ff) begin
            wr_index_ff <= (wr_index_ff == LAST) ? '0 : (wr_index_ff + AW'(1));
            phase_ff    <= phase_ff + {{(LFO_W-STEP_W){1'b0}}, step_ff};
            if (fill_ff != FULL) begin
               fill_ff <= fill_ff + FW'(1);
            end
         end
      end
   end

   // Frame payload
   always_ff @(posedge clock) begin
      if (accept) begin
         dry_l_ff <= req_if.left_in;
         dry_r_ff <= req_if.right_in;
         res_l_ff <= req_if.left_in;
         res_r_ff <= req_if.right_in;
      end else if (merge_done) begin
         res_l_ff <= mg_l;
         res_r_ff <= mg_r;
      end
      if (load_out) begin
         out_l_ff <= res_l_ff;
         out_r_ff <= res_r_ff;
      end
   end

   assign lane_cfg = '{phase: phase_ff, base_delay: base_ff, mod_depth: depth_ff};
   assign mix_cfg  = '{mix: mix_ff, width: width_ff};

   // Voice lanes
   for (genvar v = 0; v < VOICES; v++) begin : g_lane
      cho_lane #(
         .VOICE_INDEX  (v),
         .VOICES       (VOICES),
         .DELAY_DEPTH  (DELAY_DEPTH),
         .SAMPLE_BITS  (SAMPLE_BITS),
         .SINE_ENTRIES (SINE_ENTRIES)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .start      (lane_start),
         .lane_cfg   (lane_cfg),
         .wr_index   (wr_index_ff),
         .fill_count (fill_ff),
         .dry_l      (dry_l_ff),
         .dry_r      (dry_r_ff),
         .done       (lane_done[v]),
         .y_l        (lane_l[v]),
         .y_r        (lane_r[v])
      );
   end

   cho_merge #(
      .VOICES      (VOICES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .start   (merge_start),
      .mix_cfg (mix_cfg),
      .dry_l   (dry_l_ff),
      .dry_r   (dry_r_ff),
      .lane_l  (lane_l),
      .lane_r  (lane_r),
      .done    (merge_done),
      .out_l   (mg_l),
      .out_r   (mg_r)
   );

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.left_out  = out_l_ff;
   assign rsp_if.right_out = out_r_ff;

endmodule

// ===== rtl/cho_lane.sv =====
// One chorus voice: LFO sine, modulated delay, two delay lines and interpolated read.
module cho_lane #(
   parameter int VOICE_INDEX  = 0,
   parameter int VOICES       = 4,
   parameter int DELAY_DEPTH  = 4096,
   parameter int SAMPLE_BITS  = 24,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  cho_pkg::lane_cfg_type               lane_cfg,
   input  logic [$clog2(DELAY_DEPTH)-1:0]      wr_index,
   input  logic [$clog2(DELAY_DEPTH+1)-1:0]    fill_count,
   input  logic signed [SAMPLE_BITS-1:0]       dry_l,
   input  logic signed [SAMPLE_BITS-1:0]       dry_r,
   output logic                                done,
   output logic signed [SAMPLE_BITS-1:0]       y_l,
   output logic signed [SAMPLE_BITS-1:0]       y_r
);
   import cho_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int AW  = $clog2(DELAY_DEPTH);
   localparam int AW1 = AW + 1;
   localparam int IW  = $clog2(SINE_ENTRIES);
   localparam int IW1 = IW + 1;
   localparam int PW  = AW + 8;
   localparam int PW1 = PW + 1;
   localparam int XW  = IW + 16;
   localparam int DW  = ((PW > 22) ? PW : 22) + 2;

   localparam logic [IW:0]   SE_C    = IW1'(SINE_ENTRIES);
   localparam longint unsigned RECIP_L = (64'd1 << 28) / SINE_ENTRIES;
   localparam logic [22:0]   RECIP   = RECIP_L[22:0];
   localparam longint unsigned OFFS_L  = ((64'd1 << 32) / VOICES) * VOICE_INDEX;
   localparam logic [LFO_W-1:0] LANE_OFFSET = OFFS_L[LFO_W-1:0];
   localparam logic signed [DW-1:0] DMIN = DW'(256);
   localparam logic signed [DW-1:0] DMAX = DW'((DELAY_DEPTH - 2) * 256);
   localparam logic [PW:0]   SPAN    = PW1'(DELAY_DEPTH * 256);
   localparam logic [AW-1:0] LAST    = AW'(DELAY_DEPTH - 1);

   // Sequencer steps
   localparam logic [3:0] S_PHASE   = 4'd0;
   localparam logic [3:0] S_INDEX   = 4'd1;
   localparam logic [3:0] S_RECIP   = 4'd2;
   localparam logic [3:0] S_REM     = 4'd3;
   localparam logic [3:0] S_TURN    = 4'd4;
   localparam logic [3:0] S_PARAB   = 4'd5;
   localparam logic [3:0] S_SQUARE  = 4'd6;
   localparam logic [3:0] S_CORR    = 4'd7;
   localparam logic [3:0] S_SINE    = 4'd8;
   localparam logic [3:0] S_SCALE   = 4'd9;
   localparam logic [3:0] S_DELAY   = 4'd10;
   localparam logic [3:0] S_POS     = 4'd11;
   localparam logic [3:0] S_READ_A  = 4'd12;
   localparam logic [3:0] S_READ_B  = 4'd13;
   localparam logic [3:0] S_CAPTURE = 4'd14;
   localparam logic [3:0] S_INTERP  = 4'd15;

   logic              busy_ff, busy_in;
   logic [3:0]        step_ff, step_in;
   logic              done_ff, done_in;

   logic [LFO_W-1:0]  ph_ff;
   logic [IW-1:0]     idx_ff;
   logic [15:0]       rq_ff;
   logic [IW:0]       rm_ff;
   logic [15:0]       t_ff;
   logic [15:0]       p_ff;
   logic [15:0]       pp_ff;
   logic [13:0]       k_ff;
   logic signed [16:0] sin_ff;
   logic signed [37:0] mprod_ff;
   logic [PW-1:0]     d_ff;
   logic [AW-1:0]     ra_ff;
   logic [AW-1:0]     rb_ff;
   logic [7:0]        frac_ff;
   logic              va_ff;
   logic              vb_ff;
   logic signed [SB-1:0] rd_l_ff, rd_r_ff;
   logic signed [SB-1:0] s1_l_ff, s1_r_ff, s2_l_ff, s2_r_ff;
   logic signed [SB-1:0] y_l_ff, y_r_ff;

   logic signed [SB-1:0] mem_l [DELAY_DEPTH];
   logic signed [SB-1:0] mem_r [DELAY_DEPTH];

   logic [LFO_W+IW:0]   ph_prod;
   logic [XW-1:0]       x_val;
   logic [XW+22:0]      q_prod;
   logic [XW:0]         rq_se;
   logic [XW-1:0]       rm_full;
   logic [15:0]         t_in;
   logic [14:0]         h_val;
   logic [30:0]         hp;
   logic [31:0]         p_sq;
   logic [15:0]         p_diff;
   logic [28:0]         k_prod;
   logic [15:0]         q_mag;
   logic signed [16:0]  sin_in;
   logic signed [37:0]  m_prod;
   logic signed [DW-1:0] d_sum;
   logic signed [DW-1:0] d_clamp;
   logic [PW+1:0]       diff_u;
   logic [PW+1:0]       pos_full;
   logic [AW-1:0]       r_val;
   logic [AW-1:0]       rb_val;
   logic [AW-1:0]       rd_addr;
   logic signed [SB:0]  dl_l, dl_r;
   logic signed [SB+9:0] il_l, il_r;
   logic [SB:0]         yf_l, yf_r;

   // Step sequencer
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = S_PHASE;
      end else if (busy_ff) begin
         if (step_ff == S_INTERP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= S_PHASE;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   // Sine index and turn position
   assign ph_prod = ph_ff * SE_C;
   assign x_val   = {idx_ff, 16'b0};
   assign q_prod  = x_val * RECIP;
   assign rq_se   = rq_ff * SE_C;
   assign rm_full = x_val - rq_se[XW-1:0];
   assign t_in    = rq_ff + 16'(rm_ff >= SE_C);

   // Parabolic sine with shaping correction
   assign h_val  = t_ff[14:0];
   assign hp     = h_val * (16'd32768 - {1'b0, h_val});
   assign p_sq   = p_ff * p_ff;
   assign p_diff = p_ff - pp_ff;
   assign k_prod = SINE_CORR * p_diff;
   assign q_mag  = p_ff - {2'b0, k_ff};
   assign sin_in = t_ff[15] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

   // Modulated delay, saturated
   assign m_prod = sin_ff * $signed({1'b0, lane_cfg.mod_depth});
   assign d_sum  = $signed({{(DW-DELAY_W){1'b0}}, lane_cfg.base_delay})
                 + DW'(mprod_ff >>> 15);

   always_comb begin
      priority if (d_sum < DMIN) begin
         d_clamp = DMIN;
      end else if (d_sum > DMAX) begin
         d_clamp = DMAX;
      end else begin
         d_clamp = d_sum;
      end
   end

   // Read position behind the write slot, wrapped into the line
   assign diff_u   = {2'b0, wr_index, 8'b0} - {2'b0, d_ff};
   assign pos_full = diff_u[PW+1] ? (diff_u + {1'b0, SPAN}) : diff_u;
   assign r_val    = pos_full[PW-1:8];
   assign rb_val   = (r_val == LAST) ? '0 : (r_val + AW'(1));

   // Linear interpolation between the two taps
   assign dl_l = $signed({s2_l_ff[SB-1], s2_l_ff}) - $signed({s1_l_ff[SB-1], s1_l_ff});
   assign dl_r = $signed({s2_r_ff[SB-1], s2_r_ff}) - $signed({s1_r_ff[SB-1], s1_r_ff});
   assign il_l = dl_l * $signed({1'b0, frac_ff});
   assign il_r = dl_r * $signed({1'b0, frac_ff});
   assign yf_l = {s1_l_ff[SB-1], s1_l_ff} + il_l[SB+8:8];
   assign yf_r = {s1_r_ff[SB-1], s1_r_ff} + il_r[SB+8:8];

   // Datapath registers, one step at a time
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         unique case (step_ff)
            S_PHASE:   ph_ff    <= lane_cfg.phase + LANE_OFFSET;
            S_INDEX:   idx_ff   <= ph_prod[LFO_W +: IW];
            S_RECIP:   rq_ff    <= q_prod[28 +: 16];
            S_REM:     rm_ff    <= rm_full[IW:0];
            S_TURN:    t_ff     <= t_in;
            S_PARAB:   p_ff     <= hp[28:13];
            S_SQUARE:  pp_ff    <= p_sq[30:15];
            S_CORR:    k_ff     <= k_prod[28:15];
            S_SINE:    sin_ff   <= sin_in;
            S_SCALE:   mprod_ff <= m_prod;
            S_DELAY:   d_ff     <= d_clamp[PW-1:0];
            S_POS: begin
               ra_ff   <= r_val;
               rb_ff   <= rb_val;
               frac_ff <= pos_full[7:0];
            end
            S_READ_A: begin
               va_ff <= {1'b0, ra_ff} < AW1'(fill_count);
               vb_ff <= {1'b0, rb_ff} < AW1'(fill_count);
            end
            S_READ_B: begin
               s1_l_ff <= va_ff ? rd_l_ff : '0;
               s1_r_ff <= va_ff ? rd_r_ff : '0;
            end
            S_CAPTURE: begin
               s2_l_ff <= vb_ff ? rd_l_ff : '0;
               s2_r_ff <= vb_ff ? rd_r_ff : '0;
            end
            S_INTERP: begin
               y_l_ff <= yf_l[SB-1:0];
               y_r_ff <= yf_r[SB-1:0];
            end
            default: ;
         endcase
      end
   end

   // Delay lines: read the two taps, then write the new frame
   assign rd_addr = (step_ff == S_READ_B) ? rb_ff : ra_ff;

   always_ff @(posedge clock) begin
      rd_l_ff <= mem_l[rd_addr];
      rd_r_ff <= mem_r[rd_addr];
      if (busy_ff && (step_ff == S_INTERP)) begin
         mem_l[wr_index] <= dry_l;
         mem_r[wr_index] <= dry_r;
      end
   end

   assign done = done_ff;
   assign y_l  = y_l_ff;
   assign y_r  = y_r_ff;

endmodule

// ===== rtl/cho_merge.sv =====
// Voice merge: average the lanes by reciprocal multiplication and mix wet with dry.
module cho_merge #(
   parameter int VOICES      = 4,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  cho_pkg::mix_cfg_type          mix_cfg,
   input  logic signed [SAMPLE_BITS-1:0] dry_l,
   input  logic signed [SAMPLE_BITS-1:0] dry_r,
   input  logic signed [SAMPLE_BITS-1:0] lane_l [VOICES],
   input  logic signed [SAMPLE_BITS-1:0] lane_r [VOICES],
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] out_l,
   output logic signed [SAMPLE_BITS-1:0] out_r
);
   import cho_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int UW  = SB + 3;
   localparam int KS  = UW + 3;
   localparam longint unsigned RECIP_L = ((64'd1 << KS) + VOICES - 1) / VOICES;
   localparam logic [KS:0]   RECIP  = RECIP_L[KS:0];
   localparam logic [UW-1:0] BIAS   = UW'(VOICES) << (SB - 1);
   localparam logic [SB-1:0] HALF   = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [SB+18:0] YMAX = (SB+19)'((64'd1 << (SB - 1)) - 64'd1);
   localparam logic signed [SB+18:0] YMIN = -YMAX - (SB+19)'(1);

   // Merge states
   localparam logic [1:0] MG_IDLE  = 2'd0;
   localparam logic [1:0] MG_DIV   = 2'd1;
   localparam logic [1:0] MG_SCALE = 2'd2;
   localparam logic [1:0] MG_MIX   = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic          done_ff, done_in;

   logic [UW-1:0] u_l_ff, u_r_ff;
   logic [16:0]   m0_ff;
   logic [34:0]   m1p_ff;
   logic signed [SB+17:0] pd_l_ff, pw_l_ff, pd_r_ff, pw_r_ff;
   logic signed [SB-1:0]  out_l_ff, out_r_ff;

   logic signed [UW-1:0] sum_l, sum_r;
   logic [16:0]   m0_in;
   logic [UW+KS:0] qp_l, qp_r;
   logic [SB-1:0] wet_l, wet_r;
   logic [19:0]   m1_raw;
   logic [16:0]   m1;
   logic signed [SB+18:0] ys_l, ys_r, yv_l, yv_r, yc_l, yc_r;

   // Sum of the lane outputs
   always_comb begin
      sum_l = '0;
      sum_r = '0;
      for (int v = 0; v < VOICES; v++) begin
         sum_l = sum_l + UW'(lane_l[v]);
         sum_r = sum_r + UW'(lane_r[v]);
      end
   end

   assign m0_in = ({1'b0, mix_cfg.mix} > Q15_ONE) ? Q15_ONE : {1'b0, mix_cfg.mix};

   // Divide by the voice count with a scaled reciprocal, exact over the biased range
   assign qp_l = u_l_ff * RECIP;
   assign qp_r = u_r_ff * RECIP;

   // Remove the bias that kept the dividend positive
   assign wet_l = u_l_ff[SB-1:0] - HALF;
   assign wet_r = u_r_ff[SB-1:0] - HALF;

   // Channel 1 share, clamped to unity
   assign m1_raw = m1p_ff[34:15];
   assign m1     = (m1_raw > 20'(Q15_ONE)) ? Q15_ONE : m1_raw[16:0];

   // Mix sum, floor shift and saturation
   assign ys_l = (SB+19)'(pd_l_ff) + (SB+19)'(pw_l_ff);
   assign ys_r = (SB+19)'(pd_r_ff) + (SB+19)'(pw_r_ff);
   assign yv_l = ys_l >>> 15;
   assign yv_r = ys_r >>> 15;

   always_comb begin
      priority if (yv_l > YMAX) begin
         yc_l = YMAX;
      end else if (yv_l < YMIN) begin
         yc_l = YMIN;
      end else begin
         yc_l = yv_l;
      end
      priority if (yv_r > YMAX) begin
         yc_r = YMAX;
      end else if (yv_r < YMIN) begin
         yc_r = YMIN;
      end else begin
         yc_r = yv_r;
      end
   end

   // Control
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         MG_IDLE: begin
            if (start) begin
               state_in = MG_DIV;
            end
         end
         MG_DIV:   state_in = MG_SCALE;
         MG_SCALE: state_in = MG_MIX;
         MG_MIX: begin
            state_in = MG_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = MG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         MG_IDLE: begin
            if (start) begin
               u_l_ff   <= UW'(sum_l) + BIAS;
               u_r_ff   <= UW'(sum_r) + BIAS;
               m0_ff    <= m0_in;
               m1p_ff   <= m0_in * (18'(Q15_ONE) + {1'b0, mix_cfg.width});
            end
         end
         MG_DIV: begin
            u_l_ff <= qp_l[KS +: UW];
            u_r_ff <= qp_r[KS +: UW];
         end
         MG_SCALE: begin
            pd_l_ff <= dry_l * $signed({1'b0, Q15_ONE - m0_ff});
            pw_l_ff <= $signed(wet_l) * $signed({1'b0, m0_ff});
            pd_r_ff <= dry_r * $signed({1'b0, Q15_ONE - m1});
            pw_r_ff <= $signed(wet_r) * $signed({1'b0, m1});
         end
         MG_MIX: begin
            out_l_ff <= yc_l[SB-1:0];
            out_r_ff <= yc_r[SB-1:0];
         end
         default: ;
      endcase
   end

   assign done  = done_ff;
   assign out_l = out_l_ff;
   assign out_r = out_r_ff;

endmodule
